[src/mkte_pkg.sv]
// Shared types, codes and character tables for the multi-tap keypad text entry block.
// No dependencies.
package mkte_pkg;

    localparam int unsigned TimeoutWidthDefault = 16;
    localparam int unsigned CfgWidth            = 16;
    localparam logic [CfgWidth-1:0] CfgTimeoutReset = 16'd1000;

    // event kinds
    localparam logic [1:0] EV_KEY  = 2'd0;
    localparam logic [1:0] EV_MODE = 2'd1;
    localparam logic [1:0] EV_TICK = 2'd2;

    // result actions
    localparam logic [2:0] ACT_MODE    = 3'd0;
    localparam logic [2:0] ACT_COMMIT  = 3'd1;
    localparam logic [2:0] ACT_PREEDIT = 3'd2;
    localparam logic [2:0] ACT_CONFIRM = 3'd3;
    localparam logic [2:0] ACT_PINYIN  = 3'd4;

    // input modes
    localparam logic [1:0] MODE_DIGIT  = 2'd0;
    localparam logic [1:0] MODE_LOWER  = 2'd1;
    localparam logic [1:0] MODE_UPPER  = 2'd2;
    localparam logic [1:0] MODE_PINYIN = 2'd3;

    localparam logic [6:0] CHAR_SPACE = 7'd32;
    localparam logic [6:0] CHAR_ZERO  = 7'd48;
    localparam logic [6:0] CHAR_LOW_A = 7'd97;

    typedef struct packed {
        logic [2:0] action;
        logic [6:0] out_char;
        logic       confirm_previous;
        logic [1:0] mode_now;
        logic [4:0] tap_index;
        logic [4:0] group_size;
    } result_t;

    // characters on key 1
    function automatic logic [6:0] punct_char(input logic [4:0] pos);
        logic [6:0] c;
        case (pos)
            5'd0:  c = 7'h2C; // ,
            5'd1:  c = 7'h2E; // .
            5'd2:  c = 7'h3F; // ?
            5'd3:  c = 7'h3A; // :
            5'd4:  c = 7'h2F; // /
            5'd5:  c = 7'h40; // @
            5'd6:  c = 7'h3B; // ;
            5'd7:  c = 7'h3A; // :
            5'd8:  c = 7'h22; // "
            5'd9:  c = 7'h27; // '
            5'd10: c = 7'h23; // #
            5'd11: c = 7'h24; // $
            5'd12: c = 7'h25; // %
            5'd13: c = 7'h5E; // ^
            5'd14: c = 7'h26; // &
            5'd15: c = 7'h2A; // *
            5'd16: c = 7'h28; // (
            5'd17: c = 7'h29; // )
            5'd18: c = 7'h5F; // _
            5'd19: c = 7'h2B; // +
            5'd20: c = 7'h2D; // -
            5'd21: c = 7'h3D; // =
            5'd22: c = 7'h7B; // {
            5'd23: c = 7'h7D; // }
            5'd24: c = 7'h5B; // [
            5'd25: c = 7'h5D; // ]
            5'd26: c = 7'h3C; // <
            5'd27: c = 7'h3E; // >
            5'd28: c = 7'h7C; // |
            5'd29: c = 7'h5C; // backslash
            default: c = 7'h00;
        endcase
        return c;
    endfunction

    // number of characters on a key; zero for keys without a group
    function automatic logic [4:0] group_len(input logic [3:0] key);
        logic [4:0] n;
        case (key)
            4'd1:  n = 5'd30;
            4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd8: n = 5'd3;
            4'd7, 4'd9: n = 5'd4;
            default: n = 5'd0;
        endcase
        return n;
    endfunction

    // offset of a key's first letter from 'a'
    function automatic logic [4:0] letter_start(input logic [3:0] key);
        logic [4:0] s;
        case (key)
            4'd2: s = 5'd0;
            4'd3: s = 5'd3;
            4'd4: s = 5'd6;
            4'd5: s = 5'd9;
            4'd6: s = 5'd12;
            4'd7: s = 5'd15;
            4'd8: s = 5'd19;
            4'd9: s = 5'd22;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    // character at a position of a key's group; upper case where asked
    function automatic logic [6:0] group_char(input logic [3:0] key,
                                              input logic [4:0] pos,
                                              input logic       upper);
        logic [6:0] c;
        c = 7'd0;
        if (key == 4'd1) begin
            c = punct_char(pos);
        end else if (group_len(key) != 5'd0) begin
            c = CHAR_LOW_A + 7'(letter_start(key)) + 7'(pos);
            if (upper) begin
                c = c - 7'd32;
            end
        end
        return c;
    endfunction

endpackage

[src/multitap_keypad_text_entry_top.sv]
// Top level of the multi-tap keypad text entry block: event decode, state update,
// output register and skid entry. Depends on mkte_pkg.
//
// The block turns keypad events (digit key, mode key, timer tick) into text entry
// results: mode changes, committed characters, multi-tap preedit characters,
// timeout confirmations and keys handed to an external pinyin engine. It takes
// one event beat per clock cycle while in_stall is low; each event is decoded and
// the state updated in the cycle it is accepted, and its result (at most one)
// goes into the output register, or the skid entry while the output is stalled.
// An output register plus one skid entry sit between the two channels, so input
// keeps flowing while a result waits; in_stall rises only once the skid entry is
// occupied. After reset the block is in pinyin mode with no open preedit and a
// timeout of 1000 ticks. Write the timeout register only while the block is idle.
module multitap_keypad_text_entry_top
    import mkte_pkg::*;
#(
    parameter int unsigned TIMEOUT_WIDTH = TimeoutWidthDefault
)
(
    input  logic                clk,
    input  logic                rst_n,
    // configuration
    input  logic                cfg_we,
    input  logic [CfgWidth-1:0] cfg_wdata,
    // input channel
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          mode,
    input  logic [3:0]          key_digit,
    // output channel
    output logic                out_valid,
    input  logic                out_stall,
    output logic [2:0]          action,
    output logic [6:0]          out_char,
    output logic                confirm_previous,
    output logic [1:0]          mode_now,
    output logic [4:0]          tap_index,
    output logic [4:0]          group_size
);

    // timeout register
    logic [CfgWidth-1:0]      timeout_reg;

    // entry state
    logic [1:0]               cur_mode_reg, cur_mode_next;
    logic [3:0]               held_key_reg, held_key_next;
    logic [4:0]               tap_pos_reg, tap_pos_next;
    logic                     open_reg, open_next;
    logic [TIMEOUT_WIDTH-1:0] ticks_reg, ticks_next;

    // output register and skid entry
    logic                     out_valid_reg, out_valid_next;
    result_t                  out_reg, out_next;
    logic                     skid_valid_reg, skid_valid_next;
    result_t                  skid_reg, skid_next;

    logic                     in_beat;
    logic                     out_beat;
    logic                     res_valid;
    result_t                  res;

    // reload value: low TIMEOUT_WIDTH bits of the register, zero counts as one
    logic [CfgWidth+TIMEOUT_WIDTH-1:0] timeout_ext;
    logic [TIMEOUT_WIDTH-1:0]          load_ticks;
    logic [4:0]                        key_len;
    logic [4:0]                        held_len;
    logic [4:0]                        tap_step;

    assign timeout_ext = {{TIMEOUT_WIDTH{1'b0}}, timeout_reg};
    assign load_ticks  = (timeout_ext[TIMEOUT_WIDTH-1:0] == '0)
                         ? TIMEOUT_WIDTH'(1) : timeout_ext[TIMEOUT_WIDTH-1:0];

    assign key_len  = group_len(key_digit);
    assign held_len = group_len(held_key_reg);
    // next tap position on a repeated key, wrapping round the group
    assign tap_step = (tap_pos_reg + 5'd1 >= key_len) ? 5'd0 : tap_pos_reg + 5'd1;

    assign in_stall = skid_valid_reg;
    assign in_beat  = in_valid && !in_stall;
    assign out_beat = out_valid_reg && !out_stall;

    // Decode one event: next state and the result it causes, if any.
    always_comb
    begin
        cur_mode_next = cur_mode_reg;
        held_key_next = held_key_reg;
        tap_pos_next  = tap_pos_reg;
        open_next     = open_reg;
        ticks_next    = ticks_reg;
        res_valid     = 1'b0;
        res           = '0;
        res.mode_now  = cur_mode_reg;

        if (in_beat) begin
            case (mode)
                EV_MODE:
                begin
                    // step the mode and drop any open preedit
                    open_next              = 1'b0;
                    held_key_next          = '0;
                    tap_pos_next           = '0;
                    ticks_next             = '0;
                    cur_mode_next          = cur_mode_reg + 2'd1;
                    res_valid              = 1'b1;
                    res.action             = ACT_MODE;
                    res.confirm_previous   = open_reg;
                    res.mode_now           = cur_mode_reg + 2'd1;
                end
                EV_TICK:
                begin
                    if (open_reg) begin
                        if (ticks_reg > TIMEOUT_WIDTH'(1)) begin
                            ticks_next = ticks_reg - TIMEOUT_WIDTH'(1);
                        end else begin
                            // wait over: confirm the open character
                            res_valid      = 1'b1;
                            res.action     = ACT_CONFIRM;
                            res.out_char   = group_char(held_key_reg, tap_pos_reg,
                                                        cur_mode_reg == MODE_UPPER);
                            res.tap_index  = tap_pos_reg;
                            res.group_size = held_len;
                            open_next      = 1'b0;
                            held_key_next  = '0;
                            tap_pos_next   = '0;
                            ticks_next     = '0;
                        end
                    end
                end
                EV_KEY:
                begin
                    if (key_digit <= 4'd9) begin
                        res_valid = 1'b1;
                        if (cur_mode_reg == MODE_DIGIT) begin
                            res.action   = ACT_COMMIT;
                            res.out_char = CHAR_ZERO + 7'(key_digit);
                        end else if (key_digit == 4'd0) begin
                            // space; confirm an open preedit first
                            res.action           = ACT_COMMIT;
                            res.out_char         = CHAR_SPACE;
                            res.confirm_previous = open_reg;
                            res.group_size       = 5'd1;
                            open_next            = 1'b0;
                            held_key_next        = '0;
                            tap_pos_next         = '0;
                            ticks_next           = '0;
                        end else if (cur_mode_reg == MODE_PINYIN) begin
                            res.action   = ACT_PINYIN;
                            res.out_char = CHAR_ZERO + 7'(key_digit);
                        end else begin
                            // multi-tap: new key starts a group, same key advances
                            if (open_reg && held_key_reg == key_digit) begin
                                tap_pos_next = tap_step;
                            end else begin
                                tap_pos_next = '0;
                            end
                            res.confirm_previous = open_reg && (held_key_reg != key_digit);
                            held_key_next  = key_digit;
                            open_next      = 1'b1;
                            ticks_next     = load_ticks;
                            res.action     = ACT_PREEDIT;
                            res.out_char   = group_char(key_digit, tap_pos_next,
                                                        cur_mode_reg == MODE_UPPER);
                            res.tap_index  = tap_pos_next;
                            res.group_size = key_len;
                        end
                    end
                end
                default:
                begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

    // Output register with one skid entry behind it.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;

        if (skid_valid_reg) begin
            // input is held; drain the skid entry once the output moves
            if (out_beat) begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
        end else if (!out_valid_reg || out_beat) begin
            out_next       = res;
            out_valid_next = res_valid;
        end else if (res_valid) begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            timeout_reg    <= CfgTimeoutReset;
            cur_mode_reg   <= MODE_PINYIN;
            held_key_reg   <= '0;
            tap_pos_reg    <= '0;
            open_reg       <= 1'b0;
            ticks_reg      <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                timeout_reg <= cfg_wdata;
            end
            cur_mode_reg   <= cur_mode_next;
            held_key_reg   <= held_key_next;
            tap_pos_reg    <= tap_pos_next;
            open_reg       <= open_next;
            ticks_reg      <= ticks_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload registers need no reset
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid        = out_valid_reg;
    assign action           = out_reg.action;
    assign out_char         = out_reg.out_char;
    assign confirm_previous = out_reg.confirm_previous;
    assign mode_now         = out_reg.mode_now;
    assign tap_index        = out_reg.tap_index;
    assign group_size       = out_reg.group_size;

endmodule

[dv/multitap_keypad_text_entry_top_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the multi-tap keypad text entry block.
// Depends on mkte_pkg and multitap_keypad_text_entry_top; nothing else.
module multitap_keypad_text_entry_top_test
    import mkte_pkg::*;
;

    // event kind that the block must drop without a result
    localparam logic [1:0] EV_NONE = 2'd3;

    localparam int unsigned DRAIN_CYCLES = 8;      // settle time once nothing is owed
    localparam int unsigned LIMIT_CYCLES = 400000; // watchdog
    localparam int unsigned PHASE_ITEMS  = 140;
    localparam int unsigned LONG_HOLD    = 64;

    // -------------------------------------------------------------------------
    // Scoreboard: tracks the entry state, predicts the result of every accepted
    // event beat and checks result beats against the oldest prediction.
    // -------------------------------------------------------------------------
    class text_entry_scoreboard;
        result_t     pending_results[$];
        int unsigned mismatches   = 0;
        logic [15:0] timeout_ticks = CfgTimeoutReset;
        logic [1:0]  cur_mode     = MODE_PINYIN;
        logic [3:0]  held_key     = 4'd0;
        logic [4:0]  tap_pos      = 5'd0;
        logic        preedit_open = 1'b0;
        logic [15:0] ticks_left   = 16'd0;
        string       punct_row    = ",.?:/@;:\"'#$%^&*()_+-={}[]<>|\\";

        function logic [4:0] group_size_of(logic [3:0] key);
            if (key == 4'd1)
            begin
                return 5'd30;
            end
            if (key == 4'd7 || key == 4'd9)
            begin
                return 5'd4;
            end
            if (key >= 4'd2 && key <= 4'd9)
            begin
                return 5'd3;
            end
            return 5'd0;
        endfunction

        // letters go in threes from 'a'; key 7 holds four, so 8 and 9 shift by one
        function logic [6:0] tap_char(logic [3:0] key, logic [4:0] pos);
            logic [6:0] c;
            if (key == 4'd1)
            begin
                return 7'(punct_row[pos]);
            end
            c = 7'(int'(CHAR_LOW_A) + (int'(key) - 2) * 3 + (key > 4'd7 ? 1 : 0)
                   + int'(pos));
            if (cur_mode == MODE_UPPER)
            begin
                c = c - 7'd32;
            end
            return c;
        endfunction

        function void close_preedit();
            preedit_open = 1'b0;
            held_key     = 4'd0;
            tap_pos      = 5'd0;
            ticks_left   = 16'd0;
        endfunction

        function void note_event(logic [1:0] kind, logic [3:0] key);
            result_t r;
            bit      hit;
            r   = '0;
            hit = 1'b1;
            if (kind == EV_MODE)
            begin
                r.action           = ACT_MODE;
                r.confirm_previous = preedit_open;
                close_preedit();
                cur_mode = cur_mode + 2'd1;
            end
            else if (kind == EV_TICK)
            begin
                if (!preedit_open)
                begin
                    hit = 1'b0;
                end
                else if (ticks_left > 16'd1)
                begin
                    ticks_left = ticks_left - 16'd1;
                    hit        = 1'b0;
                end
                else
                begin
                    r.action     = ACT_CONFIRM;
                    r.out_char   = tap_char(held_key, tap_pos);
                    r.tap_index  = tap_pos;
                    r.group_size = group_size_of(held_key);
                    close_preedit();
                end
            end
            else if (kind != EV_KEY || key > 4'd9)
            begin
                hit = 1'b0;
            end
            else if (cur_mode == MODE_DIGIT)
            begin
                r.action   = ACT_COMMIT;
                r.out_char = CHAR_ZERO + 7'(key);
            end
            else if (key == 4'd0)
            begin
                r.action           = ACT_COMMIT;
                r.out_char         = CHAR_SPACE;
                r.confirm_previous = preedit_open;
                r.group_size       = 5'd1;
                close_preedit();
            end
            else if (cur_mode == MODE_PINYIN)
            begin
                r.action   = ACT_PINYIN;
                r.out_char = CHAR_ZERO + 7'(key);
            end
            else
            begin
                if (preedit_open && held_key == key)
                begin
                    tap_pos = 5'((int'(tap_pos) + 1) % int'(group_size_of(key)));
                end
                else
                begin
                    r.confirm_previous = preedit_open;
                    preedit_open       = 1'b1;
                    held_key           = key;
                    tap_pos            = 5'd0;
                end
                ticks_left   = (timeout_ticks == 16'd0) ? 16'd1 : timeout_ticks;
                r.action     = ACT_PREEDIT;
                r.out_char   = tap_char(key, tap_pos);
                r.tap_index  = tap_pos;
                r.group_size = group_size_of(key);
            end
            r.mode_now = cur_mode;
            if (hit)
            begin
                pending_results.push_back(r);
            end
        endfunction

        function void check_result(result_t got);
            result_t exp;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result beat: action %0d char %0d", got.action,
                       got.out_char);
                mismatches++;
                return;
            end
            exp = pending_results.pop_front();
            if (got.action !== exp.action)
            begin
                $error("action: expected %0d, got %0d", exp.action, got.action);
                mismatches++;
            end
            if (got.out_char !== exp.out_char)
            begin
                $error("out_char: expected %0d, got %0d", exp.out_char, got.out_char);
                mismatches++;
            end
            if (got.confirm_previous !== exp.confirm_previous)
            begin
                $error("confirm_previous: expected %0d, got %0d", exp.confirm_previous,
                       got.confirm_previous);
                mismatches++;
            end
            if (got.mode_now !== exp.mode_now)
            begin
                $error("mode_now: expected %0d, got %0d", exp.mode_now, got.mode_now);
                mismatches++;
            end
            if (got.tap_index !== exp.tap_index)
            begin
                $error("tap_index: expected %0d, got %0d", exp.tap_index, got.tap_index);
                mismatches++;
            end
            if (got.group_size !== exp.group_size)
            begin
                $error("group_size: expected %0d, got %0d", exp.group_size,
                       got.group_size);
                mismatches++;
            end
        endfunction
    endclass

    // -------------------------------------------------------------------------
    // Clock, DUT ports (all inputs known from time zero) and the DUT itself
    // -------------------------------------------------------------------------
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [15:0] cfg_wdata = 16'd0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [1:0]  mode      = EV_KEY;
    logic [3:0]  key_digit = 4'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  action;
    logic [6:0]  out_char;
    logic        confirm_previous;
    logic [1:0]  mode_now;
    logic [4:0]  tap_index;
    logic [4:0]  group_size;

    text_entry_scoreboard expected_text = new;

    // knobs shared between the stimulus and the result sink
    bit          send_idle    = 1'b1;
    bit          recv_idle    = 1'b1;
    bit          hold_request = 1'b0;
    int unsigned items_sent   = 0;
    logic [15:0] phase_tmo    = CfgTimeoutReset;
    logic [15:0] phase_timeout [8] = '{16'd1, 16'd0, 16'd3, 16'd65535,
                                       16'd2, 16'd5, 16'd1000, 16'd4};

    initial
    begin
        forever #2 clk = ~clk;
    end

    multitap_keypad_text_entry_top u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .mode             (mode),
        .key_digit        (key_digit),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .action           (action),
        .out_char         (out_char),
        .confirm_previous (confirm_previous),
        .mode_now         (mode_now),
        .tap_index        (tap_index),
        .group_size       (group_size)
    );

    // -------------------------------------------------------------------------
    // Sender side. Every task is entered and left just after a rising edge.
    // -------------------------------------------------------------------------

    // Offer one event beat after a random gap and hold it until accepted.
    // Valid stays high straight into the next beat when no gap is drawn.
    task automatic send_event(input logic [1:0] kind, input logic [3:0] key);
        int unsigned gap;
        gap = send_idle ? $urandom_range(0, 5) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        mode      <= kind;
        key_digit <= key;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        expected_text.note_event(kind, key);
        if (kind != EV_NONE && !(kind == EV_KEY && key > 4'd9))
        begin
            items_sent++;
        end
    endtask

    // Drop valid, wait until every predicted result has been taken, then let
    // the pipeline settle so that beats without a result have cleared too.
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_text.pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write the timeout register; only call this with the block drained.
    task automatic write_timeout(input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        expected_text.timeout_ticks = value;
        phase_tmo = value;
    endtask

    // One random burst. Mostly well-formed tap runs on one key so that the
    // multi-tap stepping and wrap-around get exercised; tick runs sized to the
    // current timeout when it is short, so that confirmations fire; a little noise.
    task automatic random_burst();
        int unsigned pick;
        int unsigned run;
        int unsigned tick_max;
        logic [3:0]  k;
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            send_event(EV_MODE, 4'($urandom));
        end
        else if (pick < 32)
        begin
            tick_max = (phase_tmo <= 16'd8) ? int'(phase_tmo) + 2 : 4;
            run = $urandom_range(1, tick_max);
            repeat (run) send_event(EV_TICK, 4'($urandom));
        end
        else if (pick < 37)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                send_event(EV_NONE, 4'($urandom));
            end
            else
            begin
                send_event(EV_KEY, 4'($urandom_range(10, 15)));
            end
        end
        else
        begin
            k = 4'($urandom_range(0, 9));
            // now and then tap key 1 a long run, at times all the way round its punctuation group
            if (k == 4'd1 && $urandom_range(0, 3) == 0)
            begin
                run = $urandom_range(25, 35);
            end
            else
            begin
                run = $urandom_range(1, 6);
            end
            repeat (run) send_event(EV_KEY, k);
        end
    endtask

    // -------------------------------------------------------------------------
    // Result sink: take result beats, draw a fresh stall per beat, and honour
    // a long hold when asked, counting it out here.
    // -------------------------------------------------------------------------
    initial
    begin : result_sink
        int unsigned stall_left;
        int unsigned hold_left;
        result_t     got;
        stall_left = 0;
        hold_left  = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                // concatenation follows the field order of result_t
                got = {action, out_char, confirm_previous, mode_now, tap_index,
                       group_size};
                expected_text.check_result(got);
                stall_left = recv_idle ? $urandom_range(0, 5) : 0;
            end
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_left != 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: give up if the run overstays its budget.
    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    // -------------------------------------------------------------------------
    // Main sequence
    // -------------------------------------------------------------------------
    initial
    begin : stimulus
        int unsigned target;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset timeout, block starts in pinyin mode.
        send_event(EV_KEY, 4'd0);        // space commits in pinyin
        send_event(EV_KEY, 4'd9);        // handed to the pinyin engine
        send_event(EV_KEY, 4'd1);
        send_event(EV_KEY, 4'd15);       // key above nine: dropped
        send_event(EV_NONE, 4'd6);       // unused event kind: dropped
        send_event(EV_TICK, 4'd0);       // tick with nothing open: no result
        send_event(EV_MODE, 4'd0);       // -> digit
        send_event(EV_KEY, 4'd0);
        send_event(EV_KEY, 4'd9);
        send_event(EV_KEY, 4'd10);       // dropped
        send_event(EV_MODE, 4'd0);       // -> lower
        repeat (5) send_event(EV_KEY, 4'd7); // p q r s and wrap back to p
        send_event(EV_KEY, 4'd9);        // other key confirms the old letter
        send_event(EV_KEY, 4'd1);
        send_event(EV_KEY, 4'd0);        // confirm then commit a space
        send_event(EV_KEY, 4'd2);
        send_event(EV_MODE, 4'd0);       // -> upper, confirms the open letter
        repeat (2) send_event(EV_KEY, 4'd9);

        // Short timeout: the second tick after the tap confirms it and the
        // third finds nothing open.
        drain();
        write_timeout(16'd2);
        send_event(EV_KEY, 4'd8);
        repeat (3) send_event(EV_TICK, 4'd0);
        send_event(EV_MODE, 4'd0);       // -> pinyin

        // Random phases, each under its own timeout; idling switched off in
        // some, and one phase where the sink holds off while beats pile up.
        for (int p = 0; p < 8; p++)
        begin
            drain();
            write_timeout((p == 5) ? 16'($urandom_range(1, 12)) : phase_timeout[p]);
            send_idle = (p != 2 && p != 3 && p != 6);
            recv_idle = (p != 2 && p != 6);
            if (p == 3)
            begin
                hold_request = 1'b1;
            end
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
            begin
                random_burst();
            end
        end

        drain();
        if (expected_text.mismatches == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[files.f]
src/mkte_pkg.sv
src/multitap_keypad_text_entry_top.sv
dv/multitap_keypad_text_entry_top_test.sv
